FILE: rtl/mcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared types and constants for the maximum clique size search block.
// ----------------------------------------------------------------------------
package mcs_pkg;

  // Fixed field widths of the edge and result transactions.
  localparam int unsigned END_W    = 5;
  localparam int unsigned CLIQUE_W = 5;
  localparam int unsigned VCOUNT_W = 5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_edge;    // an edge transaction is accepted this cycle
    logic init_search;  // seed level zero of the candidate stack
    logic step;         // one push or pop of the depth-first walk
    logic capture;      // move the best size into the result register
    logic clear_adj;    // wipe the adjacency matrix
  } mcs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic search_done;  // stack is at level zero with no candidates left
  } mcs_status_t;

endpackage : mcs_pkg
`default_nettype wire

FILE: rtl/mcs_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcs_edge_if / mcs_result_if
// Valid/ready channels for edge transactions and result transactions.
// ----------------------------------------------------------------------------
interface mcs_edge_if;
  import mcs_pkg::*;

  logic             valid;
  logic             ready;
  logic             edge_valid;
  logic [END_W-1:0] end_a;
  logic [END_W-1:0] end_b;
  logic             last_edge;

  modport source (output valid, output edge_valid, output end_a, output end_b,
                  output last_edge, input ready);
  modport sink   (input valid, input edge_valid, input end_a, input end_b,
                  input last_edge, output ready);
endinterface : mcs_edge_if

interface mcs_result_if;
  import mcs_pkg::*;

  logic                valid;
  logic                ready;
  logic [CLIQUE_W-1:0] clique_size;

  modport source (output valid, output clique_size, input ready);
  modport sink   (input valid, input clique_size, output ready);
endinterface : mcs_result_if
`default_nettype wire

FILE: rtl/max_clique_size_search_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_clique_size_search_core
// Loads a graph edge by edge and reports the size of its largest clique.
// ----------------------------------------------------------------------------
// Edge transactions are taken one per clock while the block is idle. The
// transaction marked last_edge starts the search, and no further edge is taken
// until its result has been placed in the output register. The search is a
// depth-first walk with an explicit candidate stack that does one push or one
// pop per clock. The block seeds the stack, walks it until level zero has no
// candidates left, and then captures the best size into the result register.
// If the previous result has not been taken yet, the capture cycle waits for
// it. The adjacency matrix is cleared in the capture cycle, and from the next
// cycle the block takes edges again while that result waits to be taken.
// ----------------------------------------------------------------------------
module max_clique_size_search_core import mcs_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                vertex_count_we_i,
  input  wire logic [VCOUNT_W-1:0] vertex_count_wdata_i,
  mcs_edge_if.sink                 edge_i,
  mcs_result_if.source             result_o
);

  mcs_cmd_t    cmd;
  mcs_status_t status;
  logic        in_ready;
  logic        out_valid;

  mcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (edge_i.valid),
    .in_last_i   (edge_i.last_edge),
    .in_ready_o  (in_ready),
    .out_ready_i (result_o.ready),
    .out_valid_o (out_valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mcs_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .vertex_count_we_i    (vertex_count_we_i),
    .vertex_count_wdata_i (vertex_count_wdata_i),
    .edge_valid_i         (edge_i.edge_valid),
    .end_a_i              (edge_i.end_a),
    .end_b_i              (edge_i.end_b),
    .clique_size_o        (result_o.clique_size)
  );

  assign edge_i.ready   = in_ready;
  assign result_o.valid = out_valid;

endmodule : max_clique_size_search_core
`default_nettype wire

FILE: rtl/mcs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcs_ctrl
// Controller: sequences edge loading, the depth-first search, the result
// hand-off and the adjacency clear.
// ----------------------------------------------------------------------------
module mcs_ctrl import mcs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_last_i,
  output logic             in_ready_o,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  input  wire mcs_status_t status_i,
  output mcs_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_INIT   = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_DONE   = 4'b1000
  } mcs_state_e;

  mcs_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_edge = 1'b1;
          if (in_last_i) begin
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd_o.init_search = 1'b1;
        state_d           = ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd_o.step = 1'b1;
        if (status_i.search_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Wait until the result register is free, then hand off and wipe the graph.
        if (out_free) begin
          cmd_o.capture   = 1'b1;
          cmd_o.clear_adj = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.capture) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_capture_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> (!out_valid_q || out_ready_i))
    else $error("result captured while the previous one was still pending");

  a_init_then_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |=> (state_q == ST_SEARCH))
    else $error("search did not start after initialization");

  a_no_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_edge |-> (state_q == ST_IDLE) && !cmd_o.step)
    else $error("edge loaded while a search was running");
`endif

endmodule : mcs_ctrl
`default_nettype wire

FILE: rtl/mcs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcs_datapath
// Adjacency matrix, candidate stack for the depth-first walk, best size
// tracking and the result register.
// ----------------------------------------------------------------------------
module mcs_datapath import mcs_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mcs_cmd_t            cmd_i,
  output mcs_status_t              status_o,
  input  wire logic                vertex_count_we_i,
  input  wire logic [VCOUNT_W-1:0] vertex_count_wdata_i,
  input  wire logic                edge_valid_i,
  input  wire logic [END_W-1:0]    end_a_i,
  input  wire logic [END_W-1:0]    end_b_i,
  output logic [CLIQUE_W-1:0]      clique_size_o
);

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned DW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CW = (DW > END_W) ? DW : END_W;
  localparam int unsigned NV = MAX_VERTICES;

  logic [NV-1:0]       adj_q   [NV];
  logic [NV-1:0]       cand_q  [NV+1];
  logic [DW-1:0]       depth_q;
  logic [DW-1:0]       depth_inc;
  logic [DW-1:0]       best_q;
  logic [VCOUNT_W-1:0] vc_q;
  logic [CLIQUE_W-1:0] res_q;

  logic          edge_ok;
  logic [VW-1:0] a_idx, b_idx;
  logic [CW-1:0] n_eff;
  logic [NV-1:0] init_mask;
  logic [NV-1:0] top, lsb, rem, child, adj_sel;

  // Edge decode: both endpoints in 1..MAX_VERTICES and distinct.
  assign edge_ok = edge_valid_i && (end_a_i != '0) && (end_b_i != '0) &&
                   (CW'(end_a_i) <= CW'(NV)) && (CW'(end_b_i) <= CW'(NV)) &&
                   (end_a_i != end_b_i);
  assign a_idx = VW'(end_a_i - END_W'(1));
  assign b_idx = VW'(end_b_i - END_W'(1));

  // Level zero holds vertices 1..min(vertex_count, MAX_VERTICES).
  assign n_eff = (CW'(vc_q) > CW'(NV)) ? CW'(NV) : CW'(vc_q);
  always_comb begin
    for (int r = 0; r < NV; r++) begin
      init_mask[r] = (CW'(r) < n_eff);
    end
  end

  // Take the lowest remaining candidate; everything left in the level lies
  // above it, so the child level is the rest masked by that vertex's row.
  assign top       = cand_q[depth_q];
  assign lsb       = top & (~top + NV'(1));
  assign rem       = top & ~lsb;
  assign depth_inc = depth_q + DW'(1);

  always_comb begin
    adj_sel = '0;
    for (int r = 0; r < NV; r++) begin
      adj_sel = adj_sel | (lsb[r] ? adj_q[r] : '0);
    end
  end
  assign child = rem & adj_sel;

  assign status_o.search_done = (depth_q == '0) && (top == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NV; r++) begin
        adj_q[r] <= '0;
      end
    end else begin
      for (int r = 0; r < NV; r++) begin
        if (cmd_i.clear_adj) begin
          adj_q[r] <= '0;
        end else if (cmd_i.load_edge && edge_ok) begin
          if (a_idx == VW'(r)) begin
            adj_q[r][b_idx] <= 1'b1;
          end
          if (b_idx == VW'(r)) begin
            adj_q[r][a_idx] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_search) begin
      cand_q[0] <= init_mask;
    end else if (cmd_i.step && (top != '0)) begin
      cand_q[depth_q]   <= rem;
      cand_q[depth_inc] <= child;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      best_q  <= '0;
    end else if (cmd_i.init_search) begin
      depth_q <= '0;
      best_q  <= '0;
    end else if (cmd_i.step) begin
      if (top != '0) begin
        depth_q <= depth_inc;
        if (depth_inc > best_q) begin
          best_q <= depth_inc;
        end
      end else if (depth_q != '0) begin
        depth_q <= depth_q - DW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= VCOUNT_W'(1);
    end else if (vertex_count_we_i) begin
      vc_q <= vertex_count_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_q <= CLIQUE_W'(best_q);
    end
  end

  assign clique_size_o = res_q;

`ifndef SYNTH
  a_depth_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(NV))
    else $error("search stack overflowed");

  a_best_covers_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= best_q)
    else $error("current clique larger than the recorded best");

  a_clear_wipes_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_adj |=> (adj_q[0] == '0) && (adj_q[NV-1] == '0))
    else $error("adjacency rows not cleared after a result");
`endif

endmodule : mcs_datapath
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks max_clique_size_search_core: graphs are loaded edge by edge over the
// edge channel, and every reported clique size is compared against a
// depth-first search run on a local copy of the adjacency matrix.
// ----------------------------------------------------------------------------
module testbench;
  import mcs_pkg::*;

  localparam int unsigned NVERT       = 16;
  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned TARGET_ITEMS = 1900;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic             edge_valid;
    logic [END_W-1:0] end_a;
    logic [END_W-1:0] end_b;
    logic             last_edge;
  } edge_txn_t;

  // Keeps the graph being loaded and the clique sizes still owed by the block.
  class clique_scoreboard;
    logic [NVERT-1:0]    adj_rows [NVERT];
    logic [VCOUNT_W-1:0] vertex_count;
    logic [CLIQUE_W-1:0] size_q [$];
    int unsigned         mismatch_count;

    function new();
      foreach (adj_rows[i]) adj_rows[i] = '0;
      vertex_count   = 1;
      mismatch_count = 0;
    endfunction

    function void set_vertex_count(logic [VCOUNT_W-1:0] value);
      vertex_count = value;
    endfunction

    function int pending();
      return size_q.size();
    endfunction

    // Explicit-stack search; each level holds the candidates that are adjacent
    // to every member and numbered above the last one added.
    function logic [CLIQUE_W-1:0] largest_clique();
      logic [NVERT-1:0] cand [NVERT+1];
      int depth;
      int best;
      int k;
      int n;
      n = (vertex_count > NVERT) ? NVERT : vertex_count;
      cand[0] = '0;
      for (int i = 0; i < n; i++) cand[0][i] = 1'b1;
      depth = 0;
      best  = 0;
      while (depth > 0 || cand[0] != '0) begin
        if (cand[depth] != '0) begin
          k = 0;
          while (!cand[depth][k]) k++;
          cand[depth][k]  = 1'b0;
          cand[depth + 1] = cand[depth] & adj_rows[k];
          depth++;
          if (depth > best) best = depth;
        end else begin
          depth--;
        end
      end
      return CLIQUE_W'(best);
    endfunction

    function void note_edge(edge_txn_t t);
      if (t.edge_valid && t.end_a >= 1 && t.end_b >= 1 && t.end_a <= NVERT &&
          t.end_b <= NVERT && t.end_a != t.end_b) begin
        adj_rows[t.end_a - 1][t.end_b - 1] = 1'b1;
        adj_rows[t.end_b - 1][t.end_a - 1] = 1'b1;
      end
      if (t.last_edge) begin
        size_q.insert(size_q.size(), largest_clique());
        foreach (adj_rows[i]) adj_rows[i] = '0;
      end
    endfunction

    function void check_size(logic [CLIQUE_W-1:0] got);
      logic [CLIQUE_W-1:0] want;
      if (size_q.size() == 0) begin
        $display("%0t: clique_size %0d arrived with no result pending", $time, got);
        mismatch_count++;
        return;
      end
      want = size_q.pop_front();
      if (got !== want) begin
        $display("%0t: clique_size mismatch, expected %0d, actual %0d", $time, want, got);
        mismatch_count++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                vertex_count_we_i;
  logic [VCOUNT_W-1:0] vertex_count_wdata_i;

  mcs_edge_if   edge_if ();
  mcs_result_if result_if ();

  clique_scoreboard sizes = new();
  int unsigned      item_count = 0;
  int unsigned      cycle_count = 0;
  bit               sink_calm = 1'b0;

  max_clique_size_search_core #(
    .MAX_VERTICES (NVERT)
  ) u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .vertex_count_we_i    (vertex_count_we_i),
    .vertex_count_wdata_i (vertex_count_wdata_i),
    .edge_i               (edge_if),
    .result_o             (result_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("max_clique_size_search_core verification failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len(bit calm);
    if (calm || $urandom_range(0, 9) < 5) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic edge_txn_t txn(bit ev, int a, int b, bit last);
    edge_txn_t t;
    t.edge_valid = ev;
    t.end_a      = END_W'(a);
    t.end_b      = END_W'(b);
    t.last_edge  = last;
    return t;
  endfunction

  // Random endpoint order so both fields see every vertex.
  function automatic edge_txn_t graph_edge(int a, int b);
    if ($urandom_range(0, 1)) return txn(1'b1, b, a, 1'b0);
    return txn(1'b1, a, b, 1'b0);
  endfunction

  function automatic edge_txn_t random_edge(int hi);
    int a;
    int b;
    a = $urandom_range(1, hi);
    b = $urandom_range(1, hi - 1);
    if (b >= a) b++;
    return txn(1'b1, a, b, 1'b0);
  endfunction

  // Transactions the block has to ignore: empty items, self-loops, bad endpoints.
  function automatic edge_txn_t noise_txn();
    int a;
    a = $urandom_range(0, 31);
    case ($urandom_range(0, 2))
      0: return txn(1'b0, $urandom_range(0, 31), $urandom_range(0, 31), 1'b0);
      1: return txn(1'b1, a, a, 1'b0);
      default: begin
        if ($urandom_range(0, 1)) return txn(1'b1, 0, $urandom_range(1, 16), 1'b0);
        return txn(1'b1, $urandom_range(1, 16), $urandom_range(17, 31), 1'b0);
      end
    endcase
  endfunction

  task automatic send_item(edge_txn_t t, int gap);
    if (gap > 0) begin
      edge_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    edge_if.valid      <= 1'b1;
    edge_if.edge_valid <= t.edge_valid;
    edge_if.end_a      <= t.end_a;
    edge_if.end_b      <= t.end_b;
    edge_if.last_edge  <= t.last_edge;
    do @(posedge clk_i); while (edge_if.ready !== 1'b1);
    sizes.note_edge(t);
    item_count++;
  endtask

  // Waits until every owed result is in, then lets a finishing search settle.
  task automatic drain();
    edge_if.valid <= 1'b0;
    while (sizes.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(int value);
    vertex_count_we_i    <= 1'b1;
    vertex_count_wdata_i <= VCOUNT_W'(value);
    @(posedge clk_i);
    sizes.set_vertex_count(VCOUNT_W'(value));
    vertex_count_we_i <= 1'b0;
  endtask

  task automatic emit_graph(int hi, bit calm);
    edge_txn_t graph_q [$];
    int        verts [$];
    int        k;
    int        j;
    int        tmp;
    int        d;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        repeat ($urandom_range(0, 18)) graph_q.insert(graph_q.size(), random_edge(hi));
      end
      4, 5, 6, 7: begin
        // Planted clique among shuffled vertices, plus a few stray edges.
        for (int i = 1; i <= hi; i++) verts.insert(verts.size(), i);
        for (int i = hi - 1; i > 0; i--) begin
          j        = $urandom_range(0, i);
          tmp      = verts[i];
          verts[i] = verts[j];
          verts[j] = tmp;
        end
        k = $urandom_range(2, (hi < 9) ? hi : 9);
        for (int i = 0; i < k; i++)
          for (int m = i + 1; m < k; m++)
            graph_q.insert(graph_q.size(), graph_edge(verts[i], verts[m]));
        repeat ($urandom_range(0, 6)) graph_q.insert(graph_q.size(), random_edge(hi));
      end
      default: begin
        d = (hi < 4) ? hi : $urandom_range(4, hi);
        for (int i = 1; i <= d; i++)
          for (int m = i + 1; m <= d; m++)
            if ($urandom_range(0, 9) < 6) graph_q.insert(graph_q.size(), graph_edge(i, m));
      end
    endcase
    if (graph_q.size() > 0 && $urandom_range(0, 1)) begin
      graph_q[graph_q.size() - 1].last_edge = 1'b1;
    end else begin
      graph_q.insert(graph_q.size(),
                     txn(1'b0, $urandom_range(0, 31), $urandom_range(0, 31), 1'b1));
    end
    foreach (graph_q[i]) begin
      if ($urandom_range(0, 11) == 0) send_item(noise_txn(), gap_len(calm));
      send_item(graph_q[i], gap_len(calm));
    end
  endtask

  // Result side: random backpressure with quiet stretches.
  initial begin
    int stall_left;
    stall_left = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
        sizes.check_size(result_if.clique_size);
      end
      if ($urandom_range(0, 299) == 0) sink_calm = !sink_calm;
      if (stall_left > 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        stall_left = gap_len(sink_calm);
      end
    end
  end

  initial begin
    int first_counts [7];
    int phase;
    int vcount;
    int hi;
    bit calm;
    first_counts         = '{16, 1, 0, 31, 2, 17, 3};
    rst_ni               <= 1'b0;
    vertex_count_we_i    <= 1'b0;
    vertex_count_wdata_i <= '0;
    edge_if.valid        <= 1'b0;
    edge_if.edge_valid   <= 1'b0;
    edge_if.end_a        <= '0;
    edge_if.end_b        <= '0;
    edge_if.last_edge    <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset the graph has a single vertex.
    send_item(txn(1'b0, 0, 0, 1'b1), 0);
    drain();
    write_vertex_count(16);
    // An edge in the closing transaction is loaded before the search.
    send_item(txn(1'b1, 1, 16, 1'b1), 0);
    // Triangle with a self-loop, a duplicate and out-of-range endpoints.
    send_item(txn(1'b1, 1, 2, 1'b0), 0);
    send_item(txn(1'b1, 3, 2, 1'b0), 1);
    send_item(txn(1'b1, 3, 1, 1'b0), 0);
    send_item(txn(1'b1, 5, 5, 1'b0), 0);
    send_item(txn(1'b1, 2, 1, 1'b0), 2);
    send_item(txn(1'b1, 0, 4, 1'b0), 0);
    send_item(txn(1'b1, 3, 31, 1'b0), 0);
    send_item(txn(1'b0, 31, 31, 1'b0), 0);
    send_item(txn(1'b0, 31, 31, 1'b1), 0);
    // Empty closing transaction; the matrix must have been cleared.
    send_item(txn(1'b0, 1, 2, 1'b1), 0);
    drain();
    write_vertex_count(0);
    send_item(txn(1'b1, 1, 2, 1'b1), 0);
    drain();
    write_vertex_count(31);
    send_item(txn(1'b1, 15, 16, 1'b0), 0);
    send_item(txn(1'b1, 16, 14, 1'b0), 0);
    send_item(txn(1'b1, 14, 15, 1'b1), 0);
    drain();
    write_vertex_count(2);
    send_item(txn(1'b1, 3, 4, 1'b0), 0);
    send_item(txn(1'b1, 1, 3, 1'b1), 0);
    send_item(txn(1'b1, 2, 1, 1'b1), 0);

    // Complete graph on all vertices: the longest search the block can do.
    drain();
    write_vertex_count(16);
    for (int a = 1; a < NVERT; a++)
      for (int b = a + 1; b <= NVERT; b++)
        send_item(txn(1'b1, b, a, (a == NVERT - 1) && (b == NVERT)), gap_len(1'b0));

    phase = 0;
    while (item_count < TARGET_ITEMS) begin
      if (phase < 7) begin
        vcount = first_counts[phase];
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2: vcount = $urandom_range(0, 2);
          3, 4, 5: vcount = $urandom_range(17, 31);
          default: vcount = $urandom_range(3, 16);
        endcase
      end
      drain();
      write_vertex_count(vcount);
      hi   = (vcount >= 2 && vcount <= NVERT) ? vcount : NVERT;
      calm = ($urandom_range(0, 3) == 0);
      // Graphs within a phase go back to back, results may still be waiting.
      repeat ($urandom_range(2, 8)) begin
        emit_graph(($urandom_range(0, 4) == 0) ? NVERT : hi, calm);
      end
      phase++;
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (sizes.mismatch_count == 0 && sizes.pending() == 0) begin
      $display("max_clique_size_search_core verification clean");
    end else begin
      $display("max_clique_size_search_core verification failed");
    end
    $finish;
  end

endmodule : testbench

FILE: max_clique_size_search_core.f
rtl/mcs_pkg.sv
rtl/mcs_stream_if.sv
rtl/mcs_ctrl.sv
rtl/mcs_datapath.sv
rtl/max_clique_size_search_core.sv
dv/testbench.sv
